/* rtl/alt_pkg.sv */
// Shared types, field widths, mode and register codes for the adaptive light trigger.
// No dependencies; every other file refers to this package by scoped names.
package alt_pkg;

	localparam int SAMPLE_W    = 10;
	localparam int TIME_W      = 32;
	localparam int CC_W        = 7;
	localparam int MODE_W      = 2;
	localparam int HOLD_W      = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int ENV_W       = 12;
	localparam int CMP_W       = 17;
	localparam int WINDOW_DEF  = 8;
	localparam int QUEUE_DEPTH = 4;

	localparam int SAMPLE_MAX     = 1023;
	localparam int ENV_SHRINK_GAP = 15;
	localparam int ENV_STEP       = 5;
	localparam int LINEAR_ON_MIN  = 5;
	localparam int CC_MAX         = 127;
	localparam int HYST_NUM       = 11;
	localparam int HYST_DEN       = 5;
	localparam int HOLDOFF_DEF    = 350;

	localparam logic [MODE_W-1:0] MODE_TRIGGER = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TOGGLE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CC_NUMBER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF   = 2'd2;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [TIME_W-1:0]   now_ms;
	} in_word_t;

	typedef struct packed {
		logic                send_cc;
		logic [CC_W-1:0]     cc_number;
		logic [CC_W-1:0]     cc_value;
		logic                led_on;
		logic                channel_active;
		logic [SAMPLE_W-1:0] level;
	} out_word_t;

	typedef struct packed {
		logic [TIME_W-1:0]   now_ms;
		logic [SAMPLE_W-1:0] level;
		logic                near_top;
		logic                near_floor;
	} class_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CC_W-1:0]   cc_number;
		logic [HOLD_W-1:0] holdoff_ms;
	} cfg_t;

endpackage

/* rtl/adaptive_light_trigger.sv */
// Adaptive light trigger top level: configuration registers, front pipeline,
// word queue and trigger back end. Uses alt_pkg, alt_front, alt_queue, alt_back.
//
// Takes one light sample word per clock while sample_ready is high and returns one
// result word per sample, in order. A sample enters a four-stage front pipeline
// (window sum, average by reciprocal multiply, envelope update, threshold compare),
// passes a four-word queue and is resolved in the back end, whose state update on
// channel, LED and hold-off time sets the rate: one word per cycle when nothing
// stalls. The result passes the front stages, a queue entry and the back end's result
// register. The window store has one valid bit per entry, so no clearing pass runs
// after reset. Configuration writes take effect at once and are meant for idle time.
module adaptive_light_trigger #(
	parameter int WINDOW = alt_pkg::WINDOW_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_ready,
	input  alt_pkg::in_word_t                sample_word,
	output logic                             result_valid,
	input  logic                             result_ready,
	output alt_pkg::out_word_t               result_word,
	input  logic                             cfg_we,
	input  logic [alt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [alt_pkg::CFG_DATA_W-1:0]   cfg_data
);

	alt_pkg::cfg_t   cfg_q;
	logic            fq_valid, fq_ready;
	alt_pkg::class_t fq_word;
	logic            qb_valid, qb_ready;
	alt_pkg::class_t qb_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= alt_pkg::MODE_TRIGGER;
			cfg_q.cc_number  <= '0;
			cfg_q.holdoff_ms <= alt_pkg::HOLD_W'(alt_pkg::HOLDOFF_DEF);
		end else if (cfg_we) begin
			unique case (cfg_index)
				alt_pkg::CFG_MODE: begin
					cfg_q.mode <= cfg_data[alt_pkg::MODE_W-1:0];
				end
				alt_pkg::CFG_CC_NUMBER: begin
					cfg_q.cc_number <= cfg_data[alt_pkg::CC_W-1:0];
				end
				alt_pkg::CFG_HOLDOFF: begin
					cfg_q.holdoff_ms <= cfg_data[alt_pkg::HOLD_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	alt_front #(
		.WINDOW(WINDOW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_word (sample_word),
		.cls_valid   (fq_valid),
		.cls_ready   (fq_ready),
		.cls_word    (fq_word)
	);

	alt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fq_valid),
		.in_ready (fq_ready),
		.in_word  (fq_word),
		.out_valid(qb_valid),
		.out_ready(qb_ready),
		.out_word (qb_word)
	);

	alt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cls_valid   (qb_valid),
		.cls_ready   (qb_ready),
		.cls_word    (qb_word),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_word (result_word)
	);

endmodule

/* rtl/alt_front.sv */
// Front pipeline: sample window and running sum, average by reciprocal multiply,
// envelope tracking and near-top / near-floor classification. Uses alt_pkg.
module alt_front #(
	parameter int WINDOW = alt_pkg::WINDOW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  alt_pkg::in_word_t sample_word,
	output logic              cls_valid,
	input  logic              cls_ready,
	output alt_pkg::class_t   cls_word
);

	localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W   = $clog2(alt_pkg::SAMPLE_MAX * WINDOW + 1);
	localparam int LOG_W   = $clog2(WINDOW);
	localparam int SH      = SUM_W + LOG_W;
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam longint unsigned RECIP = (longint'(1) << SH) / WINDOW + 1;
	localparam int SW = alt_pkg::SAMPLE_W;
	localparam int EW = alt_pkg::ENV_W;
	localparam int CW = alt_pkg::CMP_W;

	logic                   adv;
	logic                   acc;
	logic [SLOT_W-1:0]      slot_q;
	logic [SLOT_W-1:0]      slot_nxt;
	logic [WINDOW-1:0]      vld_q;
	logic [SW-1:0]          win_mem [WINDOW];
	logic [SW-1:0]          rd_q;
	logic [SW-1:0]          last_q;
	logic                   hit_q;
	logic                   same_q;
	logic [SW-1:0]          old_smp;
	logic [SUM_W-1:0]       sum_q;
	logic [RECIP_W-1:0]     recip;
	logic [PROD_W-1:0]      prod;
	logic                   v_s1, v_s2, v_s3, v_s4;
	logic [alt_pkg::TIME_W-1:0] now_s1, now_s2, now_s3;
	logic [SW-1:0]          avg_s2, avg_s3;
	logic signed [EW-1:0]   top_q, floor_q;
	logic signed [EW-1:0]   avg_env, top_a, floor_a, top_b, floor_b;
	logic                   shrink;
	logic signed [EW:0]     dist_top, dist_floor, span_raw;
	logic signed [CW-1:0]   span_abs, lhs_top, lhs_floor, rhs;
	logic                   near_top, near_floor;
	alt_pkg::class_t        class_s4;

	assign adv          = !v_s4 || cls_ready;
	assign sample_ready = adv;
	assign acc          = sample_valid && adv;
	assign cls_valid    = v_s4;
	assign cls_word     = class_s4;

	assign slot_nxt = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
	assign old_smp  = same_q ? last_q : (hit_q ? rd_q : '0);
	assign recip    = RECIP_W'(RECIP);
	assign prod     = PROD_W'(sum_q) * PROD_W'(recip);

	always_ff @(posedge clk) begin
		if (acc) begin
			win_mem[slot_q] <= sample_word.sample;
			rd_q            <= win_mem[slot_nxt];
			last_q          <= sample_word.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			vld_q  <= '0;
			hit_q  <= 1'b0;
			same_q <= 1'b0;
			sum_q  <= '0;
		end else if (acc) begin
			slot_q        <= slot_nxt;
			vld_q[slot_q] <= 1'b1;
			hit_q         <= vld_q[slot_nxt] && (slot_nxt != slot_q);
			same_q        <= (slot_nxt == slot_q);
			sum_q         <= sum_q - SUM_W'(old_smp) + SUM_W'(sample_word.sample);
		end
	end

	always_comb begin
		avg_env = signed'(EW'(avg_s2));
		shrink  = (floor_q + EW'(alt_pkg::ENV_SHRINK_GAP)) <= top_q;
		top_a   = shrink ? top_q - EW'(alt_pkg::ENV_STEP) : top_q;
		floor_a = shrink ? floor_q + EW'(alt_pkg::ENV_STEP) : floor_q;
		top_b   = (avg_env > top_a) ? top_a + EW'(alt_pkg::ENV_STEP) : top_a;
		floor_b = (avg_env < floor_a) ? floor_a - EW'(alt_pkg::ENV_STEP) : floor_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= EW'(alt_pkg::SAMPLE_MAX);
			floor_q <= '0;
		end else if (adv && v_s2) begin
			top_q   <= top_b;
			floor_q <= floor_b;
		end
	end

	always_comb begin
		dist_top   = (EW + 1)'(top_q) - signed'((EW + 1)'(avg_s3));
		dist_floor = signed'((EW + 1)'(avg_s3)) - (EW + 1)'(floor_q);
		span_raw   = (EW + 1)'(top_q) - (EW + 1)'(floor_q);
		span_abs   = (span_raw < 0) ? -CW'(span_raw) : CW'(span_raw);
		lhs_top    = CW'(dist_top) * CW'(alt_pkg::HYST_NUM);
		lhs_floor  = CW'(dist_floor) * CW'(alt_pkg::HYST_NUM);
		rhs        = span_abs * CW'(alt_pkg::HYST_DEN);
		near_top   = lhs_top < rhs;
		near_floor = lhs_floor < rhs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			now_s1   <= sample_word.now_ms;
			now_s2   <= now_s1;
			avg_s2   <= prod[SH +: SW];
			now_s3   <= now_s2;
			avg_s3   <= avg_s2;
			class_s4 <= '{now_ms: now_s3, level: avg_s3,
				near_top: near_top, near_floor: near_floor};
		end
	end

endmodule

/* rtl/alt_queue.sv */
// Short word queue between the front pipeline and the trigger back end.
// Uses alt_pkg for the classified word type and depth.
module alt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  alt_pkg::class_t in_word,
	output logic            out_valid,
	input  logic            out_ready,
	output alt_pkg::class_t out_word
);

	localparam int DEPTH = alt_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	alt_pkg::class_t  ent_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push, pop;

	assign in_ready  = cnt_q != CNT_W'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_word  = ent_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: begin
					cnt_q <= cnt_q + 1'b1;
				end
				2'b01: begin
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
	a_cnt_grow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not follow push");
`endif

endmodule

/* rtl/alt_back.sv */
// Trigger back end: up/down decision per mode, hold-off timing, channel and LED
// state, result register. Uses alt_pkg.
module alt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  alt_pkg::cfg_t      cfg,
	input  logic               cls_valid,
	output logic               cls_ready,
	input  alt_pkg::class_t    cls_word,
	output logic               result_valid,
	input  logic               result_ready,
	output alt_pkg::out_word_t result_word
);

	localparam int CC = alt_pkg::CC_W;
	localparam int SW = alt_pkg::SAMPLE_W;
	localparam int TW = alt_pkg::TIME_W;

	logic               pop;
	logic               linear, toggle, trig;
	logic [TW-1:0]      elapsed;
	logic               held_off;
	logic [CC-1:0]      lin_val, up_val, value;
	logic               up, down, send;
	logic               active_q, active_n;
	logic               led_q, led_n;
	logic [CC-1:0]      last_sent_q, last_sent_n;
	logic [TW-1:0]      last_up_q, last_up_n;
	logic               res_valid_q;
	alt_pkg::out_word_t res_q;

	assign cls_ready    = !res_valid_q || result_ready;
	assign pop          = cls_valid && cls_ready;
	assign result_valid = res_valid_q;
	assign result_word  = res_q;

	always_comb begin
		linear   = cfg.mode == alt_pkg::MODE_LINEAR;
		toggle   = cfg.mode == alt_pkg::MODE_TOGGLE;
		trig     = !linear && !toggle;
		elapsed  = cls_word.now_ms - last_up_q;
		held_off = elapsed >= TW'(cfg.holdoff_ms);
		lin_val  = (cls_word.level > SW'(alt_pkg::CC_MAX)) ? CC'(alt_pkg::CC_MAX)
			: cls_word.level[CC-1:0];
		priority if (toggle) begin
			up_val = (last_sent_q != '0) ? '0 : CC'(alt_pkg::CC_MAX);
		end else if (linear) begin
			up_val = lin_val;
		end else begin
			up_val = CC'(alt_pkg::CC_MAX);
		end
		up = linear ? (cls_word.level > SW'(alt_pkg::LINEAR_ON_MIN))
			: (!active_q && cls_word.near_top && held_off);
		down = !up && (linear || (active_q && cls_word.near_floor));

		send        = 1'b0;
		value       = '0;
		active_n    = active_q;
		led_n       = led_q;
		last_sent_n = last_sent_q;
		last_up_n   = last_up_q;
		if (up) begin
			active_n    = 1'b1;
			last_up_n   = cls_word.now_ms;
			send        = !linear || (up_val != '0);
			value       = send ? up_val : '0;
			led_n       = toggle ? (up_val != '0) : 1'b1;
			last_sent_n = up_val;
		end else if (down) begin
			active_n = 1'b0;
			if (!toggle) begin
				led_n = 1'b0;
			end
			send = trig;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			led_q       <= 1'b0;
			last_sent_q <= '0;
			last_up_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q    <= active_n;
				led_q       <= led_n;
				last_sent_q <= last_sent_n;
				last_up_q   <= last_up_n;
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= '{send_cc: send, cc_number: cfg.cc_number, cc_value: value,
				led_on: led_n, channel_active: active_n, level: cls_word.level};
		end
	end

`ifndef ASSERT_OFF
	a_nonzero_is_up: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.send_cc && res_q.cc_value != '0 |-> res_q.channel_active)
		else $error("nonzero value sent while channel inactive");
	a_linear_state: assert property (@(posedge clk) disable iff (!arst_n)
		pop && linear |=>
		res_q.channel_active == (res_q.level > SW'(alt_pkg::LINEAR_ON_MIN)))
		else $error("linear mode channel state does not follow level");
`endif

endmodule
